// ===== src/cfws_pkg.sv =====
// Package for the circular FIFO with search: payload structs, command codes,
// reset constants and the pointer wrap helper. No dependencies.
`default_nettype none

package cfws_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CAP_W   = 5;
  localparam int WORD_W  = 32;
  localparam int FOUND_W = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [2:0] CMD_ENQ    = 3'd0;
  localparam logic [2:0] CMD_DEQ    = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_SEARCH = 3'd4;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic                     status;
    logic signed [WORD_W-1:0] data;
    logic [FOUND_W-1:0]       found_index;
    logic [CAP_W-1:0]         count;
    logic                     empty_res;
    logic                     full_res;
  } result_t;

  // Advance a ring pointer, wrapping to zero at the effective capacity.
  function automatic logic [CAP_W-1:0] wrap_next(input logic [CAP_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] inc;
    inc = {1'b0, p} + 1'b1;
    if (inc >= {1'b0, cap}) begin
      wrap_next = '0;
    end else begin
      wrap_next = inc[CAP_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/cfws_mem.sv =====
// Word storage for the circular FIFO: one write port and one read port with
// registered read data. Depends on cfws_pkg for the word width.
`default_nettype none

module cfws_mem
  import cfws_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic signed [WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic signed [WORD_W-1:0]      rdata
);

  logic signed [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/circular_fifo_with_search.sv =====
// Circular FIFO with search: command sequencer, ring pointers and capacity
// register. Depends on cfws_pkg and the storage module cfws_mem.
//
// Usage: drive item and raise start; the command is transferred at a rising
// edge where start is high and busy is low. Each command gives exactly one
// result, shown on result for one cycle with done high; the receiver takes
// it at the edge that ends that cycle and cannot hold it off.
// Enqueue, clear, failed dequeue/peek, search of an empty queue and unknown
// codes set done at the transfer edge. Dequeue and peek go through S_READ
// for the registered memory read before done. Search goes through S_SCAN,
// comparing entries from the head up to the current count and stopping at
// the first match; the single compare unit checks one entry per cycle.
// busy is high from the transfer until the result is registered, so the
// next command may be transferred during the done cycle.
// The capacity register is written through cfg_we/cfg_data; the user must do
// so only while the block is idle, as the block does not enforce it. A write
// clears head, tail and count. Capacity is saturated to 1..min(DEPTH, 31).
// Reset (rst, synchronous) empties the queue and sets capacity to 16;
// storage contents are not cleared, and no clearing pass is needed.
`default_nettype none

module circular_fifo_with_search
  import cfws_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire item_t            item,
  output logic                  busy,
  output logic                  done,
  output result_t               result,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [CAP_W-1:0] CAP_MAX = (DEPTH > 31) ? 5'd31 : CAP_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN
  } state_t;

  state_t                   state;
  logic [CAP_W-1:0]         capacity;
  logic [CAP_W-1:0]         head;
  logic [CAP_W-1:0]         tail;
  logic [CAP_W-1:0]         occ;
  logic [CAP_W-1:0]         idx;
  logic [CAP_W-1:0]         nxt;
  logic [CAP_W-1:0]         rem;
  logic signed [WORD_W-1:0] val;
  logic                     res_status;
  logic signed [WORD_W-1:0] res_data;
  logic [FOUND_W-1:0]       res_found;

  logic [CAP_W-1:0]         cap_eff;
  logic                     accept;
  logic                     mem_we;
  logic [AW-1:0]            raddr;
  logic signed [WORD_W-1:0] rdata;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = 5'd1;
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
  end

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign mem_we = accept && (item.command == CMD_ENQ) && (occ < cap_eff);
  // Pointers never reach the effective capacity, which is at most DEPTH.
  assign raddr  = (state == S_SCAN) ? AW'(nxt) : AW'(head);

  cfws_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(AW'(tail)),
    .wdata(item.value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
      occ      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            res_status <= 1'b1;
            res_data   <= '0;
            res_found  <= '0;
            done       <= 1'b1;
            case (item.command)
              CMD_ENQ: begin
                if (occ < cap_eff) begin
                  tail       <= wrap_next(tail, cap_eff);
                  occ        <= occ + 1'b1;
                  res_status <= 1'b0;
                end
              end
              CMD_DEQ: begin
                if (occ != '0) begin
                  head       <= wrap_next(head, cap_eff);
                  occ        <= occ - 1'b1;
                  res_status <= 1'b0;
                  done       <= 1'b0;
                  state      <= S_READ;
                end
              end
              CMD_PEEK: begin
                if (occ != '0) begin
                  res_status <= 1'b0;
                  done       <= 1'b0;
                  state      <= S_READ;
                end
              end
              CMD_CLEAR: begin
                head       <= '0;
                tail       <= '0;
                occ        <= '0;
                res_status <= 1'b0;
              end
              CMD_SEARCH: begin
                if (occ != '0) begin
                  val   <= item.value;
                  idx   <= head;
                  nxt   <= wrap_next(head, cap_eff);
                  rem   <= occ;
                  done  <= 1'b0;
                  state <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          res_data <= rdata;
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        S_SCAN: begin
          // rdata holds the entry at idx; the read of nxt is under way.
          if (rdata == val) begin
            res_found  <= idx[FOUND_W-1:0];
            res_status <= 1'b0;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (rem == 5'd1) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= nxt;
            nxt <= wrap_next(nxt, cap_eff);
            rem <= rem - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        capacity <= cfg_data;
        head     <= '0;
        tail     <= '0;
        occ      <= '0;
      end
    end
  end

  // The count fields follow the occupancy, which holds still until the next
  // transfer completes the done cycle.
  assign result.status      = res_status;
  assign result.data        = res_data;
  assign result.found_index = res_found;
  assign result.count       = occ;
  assign result.empty_res   = (occ == '0);
  assign result.full_res    = (occ == cap_eff);

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= cap_eff)
    else $error("occupancy exceeds effective capacity");

  a_busy_ends_in_result: assert property (@(posedge clk) disable iff (rst)
      $fell(busy) |-> done)
    else $error("sequencer returned to idle without a result");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
      mem_we |-> (state == S_IDLE) && (occ < cap_eff))
    else $error("storage written outside an accepted enqueue");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
      done |-> !(result.empty_res && result.full_res))
    else $error("result reports empty and full together");

endmodule

`default_nettype wire

// ===== tb/tb_circular_fifo_with_search.sv =====
// Self-checking testbench for circular_fifo_with_search: directed and random
// command streams are checked against a ring-buffer predictor kept in step.
// Depends on cfws_pkg and the circular_fifo_with_search RTL.

module tb_circular_fifo_with_search;
  import cfws_pkg::*;

  localparam logic [2:0] CMD_FIRST_RSVD = 3'd5;
  localparam logic [2:0] CMD_LAST_RSVD  = 3'd7;
  localparam int RING_SLOTS  = DEPTH_DEFAULT;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             start    = 1'b0;
  item_t            item     = '0;
  logic             cfg_we   = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic             busy;
  logic             done;
  result_t          result;

  circular_fifo_with_search dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a copy of the ring, its pointers and the capacity register.
  logic signed [WORD_W-1:0] ring_words [RING_SLOTS];
  int unsigned              ring_head;
  int unsigned              ring_tail;
  int unsigned              ring_count;
  logic [CAP_W-1:0]         cap_setting;

  result_t pending_results[$];
  result_t want_r;

  int n_sent        = 0;
  int n_checked     = 0;
  int n_errors      = 0;
  int n_cap_writes  = 0;
  int n_full_rej    = 0;
  int n_empty_rej   = 0;
  int n_search_hits = 0;
  int n_search_miss = 0;
  int stall_cycles  = 0;

  function automatic int unsigned usable_slots();
    if (cap_setting == 0) begin
      return 1;
    end
    if (cap_setting > RING_SLOTS) begin
      return RING_SLOTS;
    end
    return cap_setting;
  endfunction

  function automatic int unsigned ring_next(int unsigned p);
    return (p + 1 >= usable_slots()) ? 0 : p + 1;
  endfunction

  // Applies one command to the predicted ring and returns the expected result.
  function automatic result_t apply_command(item_t it);
    result_t     r;
    int unsigned idx;
    r = '0;
    r.status = 1'b1;
    case (it.command)
      CMD_ENQ: begin
        if (ring_count < usable_slots()) begin
          ring_words[ring_tail] = it.value;
          ring_tail = ring_next(ring_tail);
          ring_count++;
          r.status = 1'b0;
        end
      end
      CMD_DEQ: begin
        if (ring_count > 0) begin
          r.data = ring_words[ring_head];
          ring_head = ring_next(ring_head);
          ring_count--;
          r.status = 1'b0;
        end
      end
      CMD_PEEK: begin
        if (ring_count > 0) begin
          r.data = ring_words[ring_head];
          r.status = 1'b0;
        end
      end
      CMD_CLEAR: begin
        ring_head = 0;
        ring_tail = 0;
        ring_count = 0;
        r.status = 1'b0;
      end
      CMD_SEARCH: begin
        // Oldest to newest; the first match wins.
        idx = ring_head;
        for (int i = 0; i < ring_count && r.status; i++) begin
          if (ring_words[idx] == it.value) begin
            r.found_index = idx[FOUND_W-1:0];
            r.status = 1'b0;
          end else begin
            idx = ring_next(idx);
          end
        end
      end
      default: begin
      end
    endcase
    r.count     = ring_count[CAP_W-1:0];
    r.empty_res = (ring_count == 0);
    r.full_res  = (ring_count == usable_slots());
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [WORD_W-1:0] want,
                                 logic [WORD_W-1:0] got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%0t: result %0d %s mismatch, expected %h got %h",
               $time, n_checked, field, want, got);
    end
  endtask

  // Start stays high across back-to-back transfers; only idle_sender drops it.
  task automatic send_cmd(logic [2:0] cmd, logic signed [WORD_W-1:0] val);
    item_t   it;
    result_t want;
    it.command = cmd;
    it.value   = val;
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = apply_command(it);
    pending_results.push_back(want);
    n_sent++;
    if (want.status) begin
      if (cmd == CMD_ENQ) begin
        n_full_rej++;
      end else if (cmd == CMD_DEQ || cmd == CMD_PEEK) begin
        n_empty_rej++;
      end else if (cmd == CMD_SEARCH) begin
        n_search_miss++;
      end
    end else if (cmd == CMD_SEARCH) begin
      n_search_hits++;
    end
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained(int settle);
    idle_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_drained(2);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_setting = v;
    ring_head   = 0;
    ring_tail   = 0;
    ring_count  = 0;
    n_cap_writes++;
  endtask

  task automatic test_empty_queue();
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_DEQ, '0);
    send_cmd(CMD_SEARCH, '0);
  endtask

  task automatic test_extreme_words();
    send_cmd(CMD_ENQ, WORD_MIN);
    send_cmd(CMD_ENQ, WORD_MAX);
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_SEARCH, WORD_MAX);
    send_cmd(CMD_SEARCH, '0);
    send_cmd(CMD_LAST_RSVD, -1);
    send_cmd(CMD_DEQ, '0);
    send_cmd(CMD_CLEAR, WORD_MAX);
    send_cmd(CMD_DEQ, '0);
  endtask

  // A two-entry ring: rejection when full, then tail and head both wrap.
  task automatic test_small_ring();
    write_capacity(5'd2);
    send_cmd(CMD_ENQ, -1);
    send_cmd(CMD_ENQ, 0);
    send_cmd(CMD_ENQ, 5);
    send_cmd(CMD_SEARCH, 0);
    send_cmd(CMD_DEQ, '0);
    send_cmd(CMD_ENQ, 7);
    send_cmd(CMD_SEARCH, 7);
    send_cmd(CMD_PEEK, '0);
    send_cmd(CMD_DEQ, '0);
    send_cmd(CMD_DEQ, '0);
    send_cmd(CMD_DEQ, '0);
  endtask

  // Traffic alternates between filling and draining the ring so that full,
  // empty and pointer wrap are reached at every capacity.
  task automatic test_random_traffic(logic [CAP_W-1:0] cap, int n_items);
    int                       r;
    int                       k;
    int                       gap;
    bit                       filling;
    logic [2:0]               cmd;
    logic signed [WORD_W-1:0] val;
    int unsigned              idx;
    write_capacity(cap);
    filling = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (ring_count == usable_slots()) begin
        filling = 1'b0;
      end else if (ring_count == 0) begin
        filling = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        cmd = filling ? CMD_ENQ : CMD_DEQ;
      end else if (r < 68) begin
        cmd = filling ? CMD_DEQ : CMD_ENQ;
      end else if (r < 76) begin
        cmd = CMD_PEEK;
      end else if (r < 93) begin
        cmd = CMD_SEARCH;
      end else if (r < 96) begin
        cmd = CMD_CLEAR;
      end else begin
        cmd = 3'($urandom_range(CMD_FIRST_RSVD, CMD_LAST_RSVD));
      end
      // Small values repeat often, so searches see duplicates.
      r = $urandom_range(0, 99);
      if (cmd == CMD_SEARCH && ring_count != 0 && r < 60) begin
        idx = ring_head;
        k = $urandom_range(0, ring_count - 1);
        repeat (k) idx = ring_next(idx);
        val = ring_words[idx];
      end else if (r < 30) begin
        val = $urandom_range(0, 6) - 3;
      end else if (r < 35) begin
        val = WORD_MIN;
      end else if (r < 40) begin
        val = WORD_MAX;
      end else begin
        val = $urandom;
      end
      send_cmd(cmd, val);
      r = $urandom_range(0, 99);
      if ((n / 25) % 3 == 0 || r < 70) begin
        gap = 0;
      end else if (r < 93) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(8, 40);
      end
      if ($urandom_range(0, 49) == 0) begin
        wait_drained(0);
      end else begin
        idle_sender(gap);
      end
    end
  endtask

  task automatic test_capacity_sweep();
    test_random_traffic(5'd1, 100);
    test_random_traffic(5'd16, 100);
    test_random_traffic(5'd0, 100);
    test_random_traffic(5'd31, 100);
    test_random_traffic(5'd17, 100);
    test_random_traffic(5'd2, 100);
    test_random_traffic(5'd8, 100);
    test_random_traffic(CAP_W'($urandom_range(3, 15)), 100);
    test_random_traffic(CAP_W'($urandom_range(0, 31)), 100);
  endtask

  // Every done cycle carries exactly one result, taken at the edge ending it.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("%0t: result arrived with no command outstanding", $time);
        end
      end else begin
        want_r = pending_results.pop_front();
        if (result.status !== want_r.status) begin
          report_mismatch("status", want_r.status, result.status);
        end
        if (result.data !== want_r.data) begin
          report_mismatch("data", want_r.data, result.data);
        end
        if (result.found_index !== want_r.found_index) begin
          report_mismatch("found_index", want_r.found_index, result.found_index);
        end
        if (result.count !== want_r.count) begin
          report_mismatch("count", want_r.count, result.count);
        end
        if (result.empty_res !== want_r.empty_res) begin
          report_mismatch("empty_res", want_r.empty_res, result.empty_res);
        end
        if (result.full_res !== want_r.full_res) begin
          report_mismatch("full_res", want_r.full_res, result.full_res);
        end
      end
      n_checked++;
    end
  end

  // Ends the run if neither a command nor a result transfer happens for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < RING_SLOTS; i++) begin
      ring_words[i] = '0;
    end
    ring_head   = 0;
    ring_tail   = 0;
    ring_count  = 0;
    cap_setting = CAP_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_extreme_words();
    test_small_ring();
    test_capacity_sweep();

    wait_drained(TAIL_CYCLES);
    $display("Sent %0d commands and checked %0d results over %0d capacity writes.",
             n_sent, n_checked, n_cap_writes);
    $display("Saw %0d full rejections, %0d empty rejections, %0d search hits, %0d misses.",
             n_full_rej, n_empty_rej, n_search_hits, n_search_miss);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches in total", n_errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cfws_pkg.sv
src/cfws_mem.sv
src/circular_fifo_with_search.sv
tb/tb_circular_fifo_with_search.sv
